FILE: sv/mts_pkg.sv
// shared types and constants for the min tracking stack
package mts_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
   localparam int CMD_W       = 2;
   localparam int DATA_W      = 32;
   localparam int COUNT_W     = 7;
   localparam int STATUS_W    = 2;

   localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

   // command codes, code 3 behaves as a peek
   localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;   // capture the incoming item
      logic exec;   // apply the operation
      logic fill;   // take top and minimum from the memory read
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_read;  // pop leaves entries, new top must come from memory
   } dp_stat_type;

endpackage

FILE: sv/mts_ctrl.sv
// control state machine for the min tracking stack
module mts_ctrl import mts_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output dp_cmd_type  dp_cmd,
   input  dp_stat_type dp_stat
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      dp_cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            dp_cmd.load = req_valid;
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            dp_cmd.exec = 1'b1;
            state_in    = dp_stat.need_read ? ST_READ : ST_RESP;
         end
         ST_READ: begin
            dp_cmd.fill = 1'b1;
            state_in    = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: sv/mts_dpath.sv
// datapath: entry memory, count, minimum and result registers
module mts_dpath import mts_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  dp_cmd_type                 dp_cmd,
   output dp_stat_type                dp_stat,
   input  logic        [CMD_W-1:0]    req_cmd,
   input  logic signed [DATA_W-1:0]   req_push_value,
   output logic signed [DATA_W-1:0]   rsp_top_value,
   output logic signed [DATA_W-1:0]   rsp_min_value,
   output logic        [COUNT_W-1:0]  rsp_entry_count,
   output logic        [STATUS_W-1:0] rsp_status
);

   // each entry holds value and prefix minimum
   logic [2*DATA_W-1:0] mem [STACK_DEPTH];
   logic [2*DATA_W-1:0] rd_data_ff;

   logic        [CMD_W-1:0]    cmd_ff;
   logic signed [DATA_W-1:0]   val_ff;
   logic        [DEPTH_W-1:0]  depth_ff, depth_in;
   logic signed [DATA_W-1:0]   min_ff, min_in;
   logic signed [DATA_W-1:0]   top_ff, top_in;
   logic        [STATUS_W-1:0] status_ff, status_in;

   logic                       is_push, is_pop, is_full, is_empty;
   logic                       wr_en;
   logic signed [DATA_W-1:0]   push_min;
   logic        [ADDR_W-1:0]   wr_addr, rd_addr;
   logic        [DEPTH_W-1:0]  depth_dec2;

   assign is_push  = (cmd_ff == CMD_PUSH);
   assign is_pop   = (cmd_ff == CMD_POP);
   assign is_full  = (depth_ff >= DEPTH_W'(STACK_DEPTH));
   assign is_empty = (depth_ff == '0);

   // current minimum equals the prefix minimum of the top entry when not empty
   assign push_min = (!is_empty && (min_ff < val_ff)) ? min_ff : val_ff;

   assign depth_dec2 = depth_ff - DEPTH_W'(2);
   assign wr_addr    = depth_ff[ADDR_W-1:0];
   assign rd_addr    = depth_dec2[ADDR_W-1:0];
   assign wr_en      = dp_cmd.exec && is_push && !is_full;

   assign dp_stat.need_read = is_pop && (depth_ff > DEPTH_W'(1));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {val_ff, push_min};
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         cmd_ff <= req_cmd;
         val_ff <= req_push_value;
      end
   end

   always_comb begin
      depth_in  = depth_ff;
      min_in    = min_ff;
      top_in    = top_ff;
      status_in = status_ff;
      if (dp_cmd.exec) begin
         status_in = STATUS_OK;
         if (is_push) begin
            if (is_full) begin
               status_in = STATUS_OVERFLOW;
            end else begin
               depth_in = depth_ff + DEPTH_W'(1);
               min_in   = push_min;
               top_in   = val_ff;
            end
         end else if (is_pop) begin
            if (is_empty) begin
               status_in = STATUS_UNDERFLOW;
            end else begin
               depth_in = depth_ff - DEPTH_W'(1);
               if (depth_ff == DEPTH_W'(1)) begin
                  // stack emptied by a pop
                  min_in = '0;
                  top_in = INT_MAX;
               end
            end
         end
      end else if (dp_cmd.fill) begin
         top_in = rd_data_ff[2*DATA_W-1:DATA_W];
         min_in = rd_data_ff[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff  <= '0;
         min_ff    <= INT_MAX;
         top_ff    <= INT_MAX;
         status_ff <= STATUS_OK;
      end else begin
         depth_ff  <= depth_in;
         min_ff    <= min_in;
         top_ff    <= top_in;
         status_ff <= status_in;
      end
   end

   assign rsp_top_value   = top_ff;
   assign rsp_min_value   = min_ff;
   assign rsp_entry_count = COUNT_W'(depth_ff);
   assign rsp_status      = status_ff;

endmodule

FILE: sv/min_tracking_stack.sv
// top level of the min tracking stack
// result: offered after the execute state, or after execute and memory fill for a pop that leaves entries
// items: one at a time, a new request is taken only once the response has been accepted on rsp_ready
// the fill state covers the registered read of the entry memory for the new top
// reset: count cleared, minimum and top read 2147483647; entry memory is not cleared,
// only entries below the count are ever used
module min_tracking_stack import mts_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic        [CMD_W-1:0]    req_cmd,
   input  logic signed [DATA_W-1:0]   req_push_value,
   // response channel
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [DATA_W-1:0]   rsp_top_value,
   output logic signed [DATA_W-1:0]   rsp_min_value,
   output logic        [COUNT_W-1:0]  rsp_entry_count,
   output logic        [STATUS_W-1:0] rsp_status
);

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   // sequencer: idle, execute, optional memory fill, respond
   mts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_cmd    (dp_cmd),
      .dp_stat   (dp_stat)
   );

   // entry memory with prefix minima, count and result registers
   mts_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .dp_cmd          (dp_cmd),
      .dp_stat         (dp_stat),
      .req_cmd         (req_cmd),
      .req_push_value  (req_push_value),
      .rsp_top_value   (rsp_top_value),
      .rsp_min_value   (rsp_min_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_status      (rsp_status)
   );

endmodule
